// ===== hw/rtl/kelp_pkg.sv =====
// Shared types and constants for the key edge / long press decoder.
// Used by kelp_button, kelp_core and key_edge_long_press_decoder_top.
package kelp_pkg;

  // Key bit positions in the key word
  localparam int KEY_SHIFT = 4;
  localparam int KEY_CTRL  = 5;
  localparam int KEY_Q     = 6;
  localparam int KEY_R     = 8;
  localparam int KEY_F     = 9;
  localparam int KEY_G     = 10;
  localparam int KEY_Z     = 11;
  localparam int KEY_C     = 13;
  localparam int KEY_B     = 15;

  localparam int KEY_W      = 16;
  localparam int HOLD_W     = 16;
  localparam int TRIG_W     = 8;
  localparam int REPEAT_W   = 16;
  localparam int THRESH_W   = 10;
  localparam int DIAL_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic [HOLD_W-1:0]   LONG_PRESS_RESET = 16'd500;
  localparam logic [TRIG_W-1:0]   TRIG_HOLD_RESET  = 8'd50;
  localparam logic [REPEAT_W-1:0] DIAL_REPEAT_RESET = 16'd300;
  localparam logic [THRESH_W-1:0] DIAL_THRESH_RESET = 10'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS  = 2'd0,
    REG_TRIG_HOLD   = 2'd1,
    REG_DIAL_REPEAT = 2'd2,
    REG_DIAL_THRESH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    SPEED_NONE      = 3'd0,
    SPEED_F_SHIFT   = 3'd1,
    SPEED_F         = 3'd2,
    SPEED_DIAL_UP   = 3'd3,
    SPEED_DIAL_DOWN = 3'd4
  } speed_t;

  typedef struct packed {
    logic [HOLD_W-1:0]   long_press_ticks;
    logic [TRIG_W-1:0]   trigger_hold_ticks;
    logic [REPEAT_W-1:0] dial_repeat_ticks;
    logic [THRESH_W-1:0] dial_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [DIAL_W-1:0] dial;
    logic                     pause_button;
    logic                     trigger_button;
    logic                     fn2_button;
    logic                     fn1_button;
    logic                     ext_link_ok;
    logic [KEY_W-1:0]         keys;
  } item_t;

  typedef struct packed {
    logic   zero_force_on;
    logic   chassis_spin;
    logic   trigger_active;
    logic   screen_redraw;
    logic   zf_flip;
    speed_t speed_adjust;
    logic   trig_reverse;
    logic   volley_flip;
    logic   rapid_flip;
    logic   shot_flip;
    logic   cap_active;
    logic   mode_flip;
  } result_t;

endpackage

// ===== hw/rtl/kelp_button.sv =====
// Short / long press decoder for one extension button.
// Saturating hold counter; a long press fires once per press. Uses kelp_pkg.
module kelp_button import kelp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              level,
  input  logic [HOLD_W-1:0] long_press_ticks,
  output logic              long_fire,
  output logic              short_release
);

  logic              button_previous;
  logic [HOLD_W-1:0] hold_count;
  logic              long_seen;
  logic [HOLD_W-1:0] hold_inc;

  always_comb begin
    hold_inc = (hold_count != {HOLD_W{1'b1}}) ? hold_count + 1'b1 : hold_count;
    long_fire = level && (hold_inc >= long_press_ticks) && !long_seen;
    short_release = !level && button_previous && !long_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_previous <= 1'b0;
      hold_count      <= '0;
      long_seen       <= 1'b0;
    end else if (en) begin
      button_previous <= level;
      if (level) begin
        hold_count <= hold_inc;
        if (long_fire) long_seen <= 1'b1;
      end else begin
        hold_count <= '0;
        long_seen  <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/kelp_core.sv =====
// Per-tick decode: key edges, latches, trigger window, dial repeat.
// Holds the tick-to-tick state; uses kelp_pkg and kelp_button.
module kelp_core import kelp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [KEY_W-1:0]    previous_keys;
  logic                spin_mode;
  logic                zero_force_latch;
  logic                cap_latch;
  logic                trigger_previous;
  logic [TRIG_W-1:0]   trigger_window;
  logic [REPEAT_W-1:0] dial_repeat;

  logic [REPEAT_W-1:0] dial_repeat_next;
  logic [TRIG_W-1:0]   trigger_window_next;
  logic [TRIG_W-1:0]   win_load;
  logic [KEY_W-1:0]    rise;
  logic                fn1, fn2, trig, pause;
  logic                fn1_long, fn1_short, fn2_long, fn2_short, pause_short;
  logic signed [DIAL_W:0] dial_x, th_pos, th_neg;
  logic                dial_up, dial_down, dial_pulse;

  // Buttons read as released while the link is down
  assign fn1   = item.ext_link_ok & item.fn1_button;
  assign fn2   = item.ext_link_ok & item.fn2_button;
  assign trig  = item.ext_link_ok & item.trigger_button;
  assign pause = item.ext_link_ok & item.pause_button;

  kelp_button u_fn1 (
    .clk(clk), .rst(rst), .en(en), .level(fn1),
    .long_press_ticks(cfg.long_press_ticks),
    .long_fire(fn1_long), .short_release(fn1_short)
  );

  kelp_button u_fn2 (
    .clk(clk), .rst(rst), .en(en), .level(fn2),
    .long_press_ticks(cfg.long_press_ticks),
    .long_fire(fn2_long), .short_release(fn2_short)
  );

  // Pause long press only suppresses the cap toggle on release
  kelp_button u_pause (
    .clk(clk), .rst(rst), .en(en), .level(pause),
    .long_press_ticks(cfg.long_press_ticks),
    .long_fire(), .short_release(pause_short)
  );

  always_comb begin
    rise = item.keys & ~previous_keys;

    win_load = (trig && !trigger_previous) ? cfg.trigger_hold_ticks : trigger_window;
    trigger_window_next = (win_load != '0) ? win_load - 1'b1 : win_load;

    dial_x = {item.dial[DIAL_W-1], item.dial};
    th_pos = $signed({2'b00, cfg.dial_threshold});
    th_neg = -th_pos;
    dial_up   = dial_x > th_pos;
    dial_down = dial_x < th_neg;
    dial_pulse = 1'b0;
    dial_repeat_next = dial_repeat;
    if (item.ext_link_ok) begin
      if (dial_up || dial_down) begin
        if (dial_repeat == '0) begin
          dial_pulse = 1'b1;
          dial_repeat_next = cfg.dial_repeat_ticks;
        end else begin
          dial_repeat_next = dial_repeat - 1'b1;
        end
      end else begin
        dial_repeat_next = '0;
      end
    end

    res.mode_flip    = rise[KEY_CTRL];
    res.cap_active   = item.keys[KEY_SHIFT] | cap_latch;
    res.shot_flip    = rise[KEY_Q] | fn1_short;
    res.rapid_flip   = rise[KEY_C] | fn1_long;
    res.volley_flip  = rise[KEY_R] | fn2_short;
    res.trig_reverse = rise[KEY_G] | fn2_long;
    if (dial_pulse) begin
      res.speed_adjust = dial_up ? SPEED_DIAL_UP : SPEED_DIAL_DOWN;
    end else if (rise[KEY_F]) begin
      res.speed_adjust = item.keys[KEY_SHIFT] ? SPEED_F_SHIFT : SPEED_F;
    end else begin
      res.speed_adjust = SPEED_NONE;
    end
    res.zf_flip           = rise[KEY_Z];
    res.screen_redraw     = rise[KEY_B];
    res.trigger_active    = win_load != '0;
    res.chassis_spin      = spin_mode ^ rise[KEY_CTRL];
    res.zero_force_on     = zero_force_latch ^ rise[KEY_Z];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys    <= '0;
      spin_mode        <= 1'b0;
      zero_force_latch <= 1'b0;
      cap_latch        <= 1'b0;
      trigger_previous <= 1'b0;
      trigger_window   <= '0;
      dial_repeat      <= '0;
    end else if (en) begin
      previous_keys    <= item.keys;
      spin_mode        <= res.chassis_spin;
      zero_force_latch <= res.zero_force_on;
      cap_latch        <= cap_latch ^ pause_short;
      trigger_previous <= trig;
      trigger_window   <= trigger_window_next;
      dial_repeat      <= dial_repeat_next;
    end
  end

endmodule

// ===== hw/rtl/key_edge_long_press_decoder_top.sv =====
// Top level of the key edge / long press decoder: stream ports, config
// registers, input and result registers. Uses kelp_pkg and kelp_core.
//
// Usage:
//  - One input transfer on the s_ side is one millisecond tick: key word,
//    extension link flag (s_tuser), four extension buttons and the dial.
//  - Every accepted tick yields exactly one result transfer on the m_ side:
//    command pulses, speed code, trigger window flag and latch states.
//  - The tick is held in an input register, decoded by short logic in
//    kelp_core and captured in the result register; m_tvalid rises when
//    the result register takes the tick from the input register.
//  - Throughput is one tick per cycle while the receiver does not stall;
//    the core state updates in the same cycle that moves a tick into the
//    result register.
//  - When the receiver stalls, the result register holds and the input
//    register keeps accepting until it is also full, then s_tready drops.
//  - Configuration writes on cfg_* are always taken (cfg_ready high); write
//    them only while no tick is in flight.
//  - Reset (rst, synchronous) restores register defaults (500, 50, 300,
//    200), clears all latches, counters and edge history, and empties both
//    stages.
module key_edge_long_press_decoder_top import kelp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // fields from bit 0: keys[15:0], fn1_button, fn2_button, trigger_button,
  // pause_button, dial[10:0], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // ext_link_ok
  input  logic                   s_tuser,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // fields from bit 0: mode_flip, cap_active, shot_flip, rapid_flip,
  // volley_flip, trig_reverse, speed_adjust[2:0], zf_flip, screen_redraw,
  // trigger_active, chassis_spin, zero_force_on, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t res;
  result_t out_res;
  logic    advance;
  logic    core_en;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks   <= LONG_PRESS_RESET;
      cfg.trigger_hold_ticks <= TRIG_HOLD_RESET;
      cfg.dial_repeat_ticks  <= DIAL_REPEAT_RESET;
      cfg.dial_threshold     <= DIAL_THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LONG_PRESS:  cfg.long_press_ticks   <= cfg_data[HOLD_W-1:0];
        REG_TRIG_HOLD:   cfg.trigger_hold_ticks <= cfg_data[TRIG_W-1:0];
        REG_DIAL_REPEAT: cfg.dial_repeat_ticks  <= cfg_data[REPEAT_W-1:0];
        REG_DIAL_THRESH: cfg.dial_threshold     <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register can take a new tick when empty or being drained
  assign advance  = !m_tvalid || m_tready;
  assign core_en  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.keys           <= s_tdata[15:0];
      in_item.fn1_button     <= s_tdata[16];
      in_item.fn2_button     <= s_tdata[17];
      in_item.trigger_button <= s_tdata[18];
      in_item.pause_button   <= s_tdata[19];
      in_item.dial           <= $signed(s_tdata[30:20]);
      in_item.ext_link_ok    <= s_tuser;
    end
  end

  kelp_core u_core (
    .clk(clk), .rst(rst), .en(core_en),
    .item(in_item), .cfg(cfg), .res(res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_en) out_res <= res;
  end

  assign m_tdata = {2'b00, out_res};

  // Input side stalls only behind a stalled, full result register
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without an output stall");

  // Speed code stays within its defined range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:6] <= SPEED_DIAL_DOWN))
    else $error("speed code out of range");

  // A tick in the input stage leaves when the result side drains
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !s_tvalid && advance) |=> (m_tvalid && !in_valid))
    else $error("tick lost between stages");

  // Both stages empty after reset
  assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_valid))
    else $error("stages not empty after reset");

endmodule
